// ----- rtl/msr_pkg.sv -----
// Shared constants, register codes and stage types of the sonar echo ranger.
`default_nettype none
package msr_pkg;

  localparam int NUM_SONARS = 5;
  localparam int ECHO_W     = 5;
  localparam int LANES      = (NUM_SONARS < ECHO_W) ? NUM_SONARS : ECHO_W;
  localparam int CH_W       = 3;
  localparam int LIM_W      = 4;
  localparam int TICK_W     = 32;
  localparam int RANGE_W    = 16;
  localparam int PERIOD_W   = 20;
  localparam int PULSE_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd5;

  typedef struct packed {
    logic [RANGE_W-1:0]  range_lo;
    logic [RANGE_W-1:0]  range_hi;
    logic [PERIOD_W-1:0] period;
    logic [PULSE_W-1:0]  pulse;
    logic [15:0]         scale;
    logic [2:0]          active;
  } cfg_t;

  typedef struct packed {
    logic [ECHO_W-1:0]            lines;
    logic [LANES-1:0]             fin;
    logic [LANES-1:0][TICK_W-1:0] elapsed;
  } capt_item_t;

  typedef struct packed {
    logic [ECHO_W-1:0]             lines;
    logic [LANES-1:0]              fin;
    logic [LANES-1:0][TICK_W-1:0]  elapsed;
    logic [LANES-1:0][RANGE_W-1:0] range;
  } scaled_item_t;

  typedef struct packed {
    logic             fire;
    logic             last;
    logic [LANES-1:0] rem;
  } emit_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/multi_sonar_echo_ranger.sv -----
// Top level of the multi-channel ultrasonic echo ranger.
// The first result of a tick request passes the capture, scale and output registers.
// Throughput: one tick request per cycle while each tick gives one result and the output
// is not stalled; a tick with several finished channels holds the emitter and the input.
// Reset: synchronous, active high; clears all timing state, empties the pipeline and
// loads the register defaults.
`default_nettype none
module multi_sonar_echo_ranger
  import msr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [4:0] echo_levels
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [63:0]                m_axis_tdata,   // [4:0] trigger_lines, [7:5] channel,
                                                     // [39:8] echo time in ticks,
                                                     // [55:40] range_mm, [56] bounds flag
  output logic                       m_axis_tuser,   // [0] meas_valid
  output logic                       m_axis_tlast,   // last result of the tick
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                          cfg;
  logic                          fire;
  logic [ECHO_W-1:0]             lines;
  logic [LANES-1:0]              fin;
  logic [LANES-1:0][TICK_W-1:0]  elapsed;
  logic                          capt_valid;
  capt_item_t                    capt;
  logic                          scale_ready;
  logic                          item_valid;
  scaled_item_t                  item;
  emit_ctl_t                     ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_lo <= RANGE_W'(50);
      cfg.range_hi <= RANGE_W'(10000);
      cfg.period   <= PERIOD_W'(50000);
      cfg.pulse    <= PULSE_W'(10);
      cfg.scale    <= 16'd11239;
      cfg.active   <= 3'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_RANGE: cfg.range_lo <= cfg_data[RANGE_W-1:0];
        REG_MAX_RANGE: cfg.range_hi <= cfg_data[RANGE_W-1:0];
        REG_PERIOD:    cfg.period   <= cfg_data[PERIOD_W-1:0];
        REG_PULSE:     cfg.pulse    <= cfg_data[PULSE_W-1:0];
        REG_SCALE:     cfg.scale    <= cfg_data[15:0];
        REG_ACTIVE:    cfg.active   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !capt_valid || scale_ready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  msr_trigger u_trigger (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .cfg   (cfg),
    .lines (lines)
  );

  msr_capture u_capture (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .echo_in (s_axis_tdata[ECHO_W-1:0]),
    .fin     (fin),
    .elapsed (elapsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capt_valid <= 1'b0;
    end else if (s_axis_tready) begin
      capt_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      capt.lines   <= lines;
      capt.fin     <= fin;
      capt.elapsed <= elapsed;
    end
  end

  msr_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (capt_valid),
    .in_ready   (scale_ready),
    .in_item    (capt),
    .scale      (cfg.scale),
    .ctl        (ctl),
    .item_valid (item_valid),
    .item       (item)
  );

  msr_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .cfg           (cfg),
    .ctl           (ctl),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/msr_trigger.sv -----
// Round-robin trigger scheduler that starts at most one pulse per period.
`default_nettype none
module msr_trigger
  import msr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire cfg_t              cfg,
  output logic [ECHO_W-1:0]      lines
);

  logic [PERIOD_W-1:0] period_count, period_count_next;
  logic [PULSE_W-1:0]  pulse_count, pulse_count_next;
  logic                pulse_active, pulse_active_next;
  logic [CH_W-1:0]     next_sonar, next_sonar_next;
  logic [PERIOD_W-1:0] period_eff;
  logic [PULSE_W-1:0]  pulse_eff;
  logic [LIM_W-1:0]    lim;

  always_comb begin
    period_eff = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
    pulse_eff  = (cfg.pulse == '0) ? PULSE_W'(1) : cfg.pulse;
    if (cfg.active == '0) begin
      lim = LIM_W'(1);
    end else if ({1'b0, cfg.active} > LIM_W'(NUM_SONARS)) begin
      lim = LIM_W'(NUM_SONARS);
    end else begin
      lim = {1'b0, cfg.active};
    end

    period_count_next = period_count + PERIOD_W'(1);
    pulse_count_next  = pulse_count;
    pulse_active_next = pulse_active;
    next_sonar_next   = next_sonar;
    lines             = '0;

    if (period_count_next >= period_eff) begin
      period_count_next = '0;
      if (!pulse_active) begin
        if ({1'b0, next_sonar_next} >= lim) begin
          next_sonar_next = '0;
        end
        pulse_active_next = 1'b1;
        pulse_count_next  = '0;
      end
    end
    if (pulse_active_next) begin
      lines            = ECHO_W'(1) << next_sonar_next;
      pulse_count_next = pulse_count_next + PULSE_W'(1);
      if (pulse_count_next >= pulse_eff) begin
        pulse_active_next = 1'b0;
        pulse_count_next  = '0;
        next_sonar_next   = next_sonar_next + CH_W'(1);
        if ({1'b0, next_sonar_next} >= lim) begin
          next_sonar_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      pulse_count  <= '0;
      pulse_active <= 1'b0;
      next_sonar   <= '0;
    end else if (fire) begin
      period_count <= period_count_next;
      pulse_count  <= pulse_count_next;
      pulse_active <= pulse_active_next;
      next_sonar   <= next_sonar_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/msr_capture.sv -----
// Tick counter and per-channel echo edge capture giving elapsed echo time.
`default_nettype none
module msr_capture
  import msr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     fire,
  input  wire logic [ECHO_W-1:0]        echo_in,
  output logic [LANES-1:0]              fin,
  output logic [LANES-1:0][TICK_W-1:0]  elapsed
);

  logic [TICK_W-1:0]            tick_count;
  logic [LANES-1:0]             previous_echo;
  logic [LANES-1:0][TICK_W-1:0] echo_start;
  logic [LANES-1:0]             echo;
  logic [LANES-1:0]             rise;
  logic [LANES-1:0]             fall;

  always_comb begin
    echo = echo_in[LANES-1:0];
    rise = echo & ~previous_echo;
    fall = ~echo & previous_echo;
    for (int i = 0; i < LANES; i++) begin
      elapsed[i] = tick_count - echo_start[i];
      fin[i]     = fall[i] && (elapsed[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      previous_echo <= '0;
      echo_start    <= '0;
    end else if (fire) begin
      tick_count    <= tick_count + TICK_W'(1);
      previous_echo <= echo;
      for (int i = 0; i < LANES; i++) begin
        if (rise[i]) begin
          echo_start[i] <= tick_count;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/msr_scale.sv -----
// Range stage: one multiplier per channel turns elapsed ticks into millimeters.
`default_nettype none
module msr_scale
  import msr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire capt_item_t   in_item,
  input  wire logic [15:0]  scale,
  input  wire emit_ctl_t    ctl,
  output logic              item_valid,
  output scaled_item_t      item
);

  logic [LANES-1:0][TICK_W+15:0]  prod;
  logic [LANES-1:0][RANGE_W-1:0]  range_sat;
  logic                           load;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod[i]      = (TICK_W+16)'(in_item.elapsed[i]) * (TICK_W+16)'(scale);
      range_sat[i] = (prod[i][TICK_W+15:TICK_W] != '0) ? '1 : prod[i][TICK_W-1:16];
    end
  end

  assign in_ready = !item_valid || (ctl.fire && ctl.last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (ctl.fire && ctl.last) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.lines   <= in_item.lines;
      item.fin     <= in_item.fin;
      item.elapsed <= in_item.elapsed;
      item.range   <= range_sat;
    end else if (ctl.fire && !ctl.last) begin
      item.fin <= ctl.rem;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/msr_emit.sv -----
// Result emitter: sends one result per finished channel, or one idle result.
`default_nettype none
module msr_emit
  import msr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire scaled_item_t  item,
  input  wire cfg_t          cfg,
  output emit_ctl_t          ctl,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata,
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);

  logic [CH_W-1:0]    idx;
  logic               has;
  logic [RANGE_W-1:0] sel_range;
  logic [TICK_W-1:0]  sel_elapsed;
  logic               sel_error;
  logic               out_free;
  logic [63:0]        data_next;

  always_comb begin
    idx = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (item.fin[i]) begin
        idx = CH_W'(i);
      end
    end
    has         = |item.fin;
    sel_range   = item.range[idx];
    sel_elapsed = item.elapsed[idx];
    sel_error   = (sel_range < cfg.range_lo) || (sel_range > cfg.range_hi);
    out_free    = !m_axis_tvalid || m_axis_tready;

    ctl.fire = item_valid && out_free;
    ctl.rem  = has ? (item.fin & ~(LANES'(1) << idx)) : '0;
    ctl.last = (ctl.rem == '0);

    data_next        = '0;
    data_next[4:0]   = item.lines;
    if (has) begin
      data_next[7:5]   = idx;
      data_next[39:8]  = sel_elapsed;
      data_next[55:40] = sel_range;
      data_next[56]    = sel_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      m_axis_tdata <= data_next;
      m_axis_tuser <= has;
      m_axis_tlast <= ctl.last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/msr_checker.sv -----
// Port checker for the echo ranger and its bind to the top level.
`default_nettype none
module msr_checker
  import msr_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [63:0]  m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Stalled result changed.");

  a_idle_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[63:5] == '0))
    else $error("Idle result is not a clean last result.");

  a_one_trigger: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[4:0]))
    else $error("More than one trigger line high.");

  a_meas_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[39:8] != '0) && (m_axis_tdata[7:5] < CH_W'(LANES)))
    else $error("Measurement with zero time or bad channel.");

  a_trigger_same: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
      m_axis_tdata[4:0] == $past(m_axis_tdata[4:0]))
    else $error("Trigger lines differ within one tick.");

endmodule

bind multi_sonar_echo_ranger msr_checker u_msr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ----- verif/multi_sonar_echo_ranger_chk.sv -----
// Checker for the sonar echo ranger: follows the tick, register and result channels and compares.
`timescale 1ns / 1ps
module multi_sonar_echo_ranger_chk
  import msr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [63:0]           m_axis_tdata,
  input  wire logic                  m_axis_tuser,
  input  wire logic                  m_axis_tlast,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [ECHO_W-1:0]  lines;
    logic               meas;
    logic [CH_W-1:0]    chan;
    logic [TICK_W-1:0]  elapsed;
    logic [RANGE_W-1:0] range_mm;
    logic               err;
    logic               last;
  } sonar_result_t;

  cfg_t                regs;
  logic [TICK_W-1:0]   tick_now;
  logic [ECHO_W-1:0]   echo_prev;
  logic [TICK_W-1:0]   rise_tick [LANES];
  logic [PERIOD_W-1:0] period_cnt;
  logic [PULSE_W-1:0]  pulse_cnt;
  logic                pulse_on;
  logic [2:0]          next_ch;
  sonar_result_t       expected_q [$];

  task automatic reset_model();
    regs.range_lo = 16'd50;
    regs.range_hi = 16'd10000;
    regs.period   = 20'd50000;
    regs.pulse    = 10'd10;
    regs.scale    = 16'd11239;
    regs.active   = 3'd5;
    tick_now   = '0;
    echo_prev  = '0;
    period_cnt = '0;
    pulse_cnt  = '0;
    pulse_on   = 1'b0;
    next_ch    = '0;
    for (int i = 0; i < LANES; i++) begin
      rise_tick[i] = '0;
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MIN_RANGE: regs.range_lo = data[RANGE_W-1:0];
      REG_MAX_RANGE: regs.range_hi = data[RANGE_W-1:0];
      REG_PERIOD:    regs.period   = data[PERIOD_W-1:0];
      REG_PULSE:     regs.pulse    = data[PULSE_W-1:0];
      REG_SCALE:     regs.scale    = data[15:0];
      REG_ACTIVE:    regs.active   = data[2:0];
      default: ;
    endcase
  endtask

  function automatic logic [2:0] rotation_size();
    if (regs.active == 3'd0) return 3'd1;
    if (32'(regs.active) > NUM_SONARS) return 3'(NUM_SONARS);
    return regs.active;
  endfunction

  // Round-robin trigger scheduler; returns the trigger lines of the current tick.
  task automatic advance_trigger(output logic [ECHO_W-1:0] lines);
    logic [PERIOD_W-1:0] period_len;
    logic [PULSE_W-1:0]  pulse_len;
    period_len = regs.period;
    if (period_len == '0) period_len = PERIOD_W'(1);
    pulse_len = regs.pulse;
    if (pulse_len == '0) pulse_len = PULSE_W'(1);
    lines = '0;
    period_cnt = period_cnt + PERIOD_W'(1);
    if (period_cnt >= period_len) begin
      period_cnt = '0;
      if (!pulse_on) begin
        if (next_ch >= rotation_size()) next_ch = '0;
        pulse_on  = 1'b1;
        pulse_cnt = '0;
      end
    end
    if (pulse_on) begin
      if (32'(next_ch) < ECHO_W) lines[next_ch] = 1'b1;
      pulse_cnt = pulse_cnt + PULSE_W'(1);
      if (pulse_cnt >= pulse_len) begin
        pulse_on  = 1'b0;
        pulse_cnt = '0;
        next_ch   = next_ch + 3'd1;
        if (next_ch >= rotation_size()) next_ch = '0;
      end
    end
  endtask

  task automatic predict_tick(input logic [ECHO_W-1:0] echo);
    logic [ECHO_W-1:0] lines;
    logic [TICK_W-1:0] span;
    logic [47:0]       prod;
    sonar_result_t     r;
    sonar_result_t     found [LANES];
    int                nfound;
    nfound = 0;
    advance_trigger(lines);
    for (int i = 0; i < LANES; i++) begin
      if (echo[i] && !echo_prev[i]) begin
        rise_tick[i] = tick_now;
      end else if (!echo[i] && echo_prev[i]) begin
        span = tick_now - rise_tick[i];
        if (span != '0) begin
          prod       = 48'(span) * 48'(regs.scale);
          r          = '0;
          r.lines    = lines;
          r.meas     = 1'b1;
          r.chan     = CH_W'(i);
          r.elapsed  = span;
          r.range_mm = (prod[47:32] != '0) ? 16'hFFFF : prod[31:16];
          r.err      = (r.range_mm < regs.range_lo) || (r.range_mm > regs.range_hi);
          found[nfound] = r;
          nfound++;
        end
      end
    end
    if (nfound == 0) begin
      r         = '0;
      r.lines   = lines;
      found[0]  = r;
      nfound    = 1;
    end
    found[nfound-1].last = 1'b1;
    for (int k = 0; k < nfound; k++) expected_q.insert(expected_q.size(), found[k]);
    echo_prev = echo;
    tick_now  = tick_now + TICK_W'(1);
  endtask

  function automatic int field_bad(input string what, input logic [31:0] want, got);
    if (want === got) return 0;
    $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    sonar_result_t want;
    int            bad;
    if (rst) begin
      reset_model();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none got %0h", $time,
                   m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          bad = field_bad("trigger_lines", 32'(want.lines), 32'(m_axis_tdata[4:0]))
              + field_bad("meas_valid", 32'(want.meas), 32'(m_axis_tuser))
              + field_bad("channel", 32'(want.chan), 32'(m_axis_tdata[7:5]))
              + field_bad("echo time", want.elapsed, m_axis_tdata[39:8])
              + field_bad("range_mm", 32'(want.range_mm), 32'(m_axis_tdata[55:40]))
              + field_bad("bounds flag", 32'(want.err), 32'(m_axis_tdata[56]))
              + field_bad("last", 32'(want.last), 32'(m_axis_tlast));
          if (bad != 0) fail_count++;
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) predict_tick(s_axis_tdata[ECHO_W-1:0]);
    end
    pending = expected_q.size();
  end

endmodule

// ----- verif/multi_sonar_echo_ranger_tb.sv -----
// Testbench top for the sonar echo ranger: clock, reset, tick and register stimulus, verdict.
`timescale 1ns / 1ps
module multi_sonar_echo_ranger_tb
  import msr_pkg::*;
;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [63:0]           m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  logic              steady = 1'b0;
  logic              hold_req = 1'b0;
  logic              hold_done = 1'b0;
  int                hold_left = 0;
  logic [ECHO_W-1:0] echo_state = '0;
  logic [ECHO_W-1:0] directed_echo [$] = '{5'h00, 5'h1F, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F,
                                           5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h15,
                                           5'h0A, 5'h15, 5'h00};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_sonar_echo_ranger u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  multi_sonar_echo_ranger_chk u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Result receiver; one long hold-off lets the block fill up and stall its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  task automatic send_tick(input logic [ECHO_W-1:0] echo);
    while (!steady && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, echo};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [19:0] period, input logic [9:0] pulse,
                               input logic [15:0] scale, input logic [2:0] active);
    write_reg(REG_MIN_RANGE, 20'(lo));
    write_reg(REG_MAX_RANGE, 20'(hi));
    write_reg(REG_PERIOD, period);
    write_reg(REG_PULSE, 20'(pulse));
    write_reg(REG_SCALE, 20'(scale));
    write_reg(REG_ACTIVE, 20'(active));
    cfg_valid <= 1'b0;
  endtask

  // Echo lines mostly change a few bits per tick so that pulses of varied length form;
  // now and then the whole pattern jumps.
  task automatic run_phase(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        echo_state = ECHO_W'($urandom_range(31));
      end else begin
        for (int b = 0; b < ECHO_W; b++) begin
          if ($urandom_range(5) == 0) echo_state[b] = ~echo_state[b];
        end
      end
      send_tick(echo_state);
    end
    drain();
  endtask

  initial begin
    int w;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    steady <= 1'b1;
    foreach (directed_echo[k]) send_tick(directed_echo[k]);
    drain();

    load_settings(16'd0, 16'hFFFF, 20'd1, 10'd1, 16'hFFFF, 3'd5);
    run_phase(30);
    steady <= 1'b0;

    write_reg(REG_SPARE_LO, 20'($urandom));
    write_reg(REG_SPARE_HI, 20'($urandom));
    load_settings(16'd3, 16'd9, 20'd0, 10'd0, 16'd32768, 3'd0);
    run_phase(30);

    load_settings(16'hFFFF, 16'd0, 20'd3, 10'd5, 16'd1, 3'd7);
    run_phase(30);

    load_settings(16'($urandom_range(200)), 16'($urandom_range(2000, 200)), 20'd4, 10'd2,
                  16'd11239, 3'd5);
    hold_req <= 1'b1;
    run_phase(30);

    load_settings(16'($urandom_range(100)), 16'($urandom_range(65535, 100)), 20'd2, 10'd1,
                  16'($urandom), 3'd3);
    run_phase(30);

    load_settings(16'($urandom_range(100)), 16'($urandom_range(65535, 100)), 20'd5, 10'd3,
                  16'($urandom), 3'd1);
    run_phase(30);

    load_settings(16'd20, 16'd40, 20'd2, 10'd1023, 16'd4000, 3'd6);
    run_phase(30);
    s_axis_tvalid <= 1'b0;

    for (w = 0; w < 2000 && pending != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
